/* rtl/core/smf_pkg.sv */
// Shared constants, config register codes and types of the smoothing filter.
package smf_pkg;

  // Sizes
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 15;
  localparam int PTR_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W       = SAMPLE_BITS + PTR_W;
  localparam int SMOOTH_W    = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int DIFF_W      = SMOOTH_W + 1;
  localparam int ALPHA_W     = 16;
  localparam int PROD_W      = ALPHA_W + 1 + DIFF_W;
  localparam int WLEN_W      = 7;
  localparam int CRS_W       = 32;
  localparam int STEP_W      = $clog2(SUM_W + 1);
  localparam int SMP_MAX     = (1 << (SAMPLE_BITS - 1)) - 1;

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_WLEN  = 2'd1,
    CFG_ALPHA = 2'd2
  } cfg_idx_e;

  // Reset values of the config registers
  localparam logic              MODE_RST  = 1'b0;
  localparam logic [WLEN_W-1:0] WLEN_RST  = WLEN_W'(8);
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(16384);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << FRAC_BITS);

  // Request to the iterative divider
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

endpackage

/* rtl/core/smf_if.sv */
// Valid/ready channel interfaces for sample beats and result beats.
interface smf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [smf_pkg::SAMPLE_BITS-1:0] sample;
  logic                                   last_in_record;

  modport source (output valid, output sample, output last_in_record, input ready);
  modport sink   (input valid, input sample, input last_in_record, output ready);
endinterface

interface smf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [smf_pkg::SAMPLE_BITS-1:0] filtered;
  logic [smf_pkg::CRS_W-1:0]              crossing_count;
  logic                                   is_last;

  modport source (output valid, output filtered, output crossing_count, output is_last,
                  input ready);
  modport sink   (input valid, input filtered, input crossing_count, input is_last,
                  output ready);
endinterface

/* rtl/core/smf_hist_ram.sv */
// Single-port-write, single-port-read sample history RAM with registered read.
module smf_hist_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/core/smf_div.sv */
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module smf_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  smf_pkg::div_req_t                req_i,
  output logic                             done_o,
  output logic signed [smf_pkg::SUM_W-1:0] quot_o
);

  logic                        busy_q;
  logic                        done_q;
  logic                        neg_q;
  logic [smf_pkg::STEP_W-1:0]  cnt_q;
  logic [smf_pkg::CNT_W-1:0]   dvs_q;
  logic [smf_pkg::CNT_W-1:0]   rem_q;
  logic [smf_pkg::SUM_W-1:0]   quo_q;
  logic [smf_pkg::SUM_W-1:0]   mag;
  logic [smf_pkg::CNT_W:0]     rem_sh;
  logic [smf_pkg::CNT_W:0]     rem_sub;
  logic                        ge;

  // Magnitude of the dividend and one restoring step
  always_comb begin
    mag     = req_i.dividend[smf_pkg::SUM_W-1] ? smf_pkg::SUM_W'(-req_i.dividend)
                                               : smf_pkg::SUM_W'(req_i.dividend);
    rem_sh  = {rem_q, quo_q[smf_pkg::SUM_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= smf_pkg::STEP_W'(smf_pkg::SUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - smf_pkg::STEP_W'(1);
        if (cnt_q == smf_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[smf_pkg::SUM_W-1];
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= mag;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[smf_pkg::CNT_W-1:0] : rem_sh[smf_pkg::CNT_W-1:0];
      quo_q <= {quo_q[smf_pkg::SUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? $signed(-quo_q) : $signed(quo_q);

endmodule

/* rtl/core/smoothing_filter_mavg_or_first_order_core.sv */
// Top level: moving average / exponential smoothing with zero-crossing count.
//
//  channel    dir  beat contents
//  in_ch_i    in   sample, last_in_record
//  out_ch_o   out  filtered, crossing_count, is_last
//  cfg_*      in   write enable, register index, write data
//
// Each sample goes from accept to the next accept through n reads, where n is the
// number of samples averaged, made through the single history read port, and then
// the 22-step divider. The smoothing multiply runs under the reads.
// Reset clears all control and record state; history holds no valid bits since
// only entries of the current record are read. A result waits in the output
// register while the next sample is taken; it stalls the core only at finish.
module smoothing_filter_mavg_or_first_order_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [smf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [smf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  smf_in_if.sink                           in_ch_i,
  smf_out_if.source                        out_ch_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_e;

  // Saturate a wide signed value to the sample range
  function automatic logic signed [smf_pkg::SAMPLE_BITS-1:0] sat_smp(
    input logic signed [smf_pkg::DIFF_W-1:0] v
  );
    logic signed [smf_pkg::DIFF_W-1:0] hi;
    logic signed [smf_pkg::DIFF_W-1:0] lo;
    hi = smf_pkg::DIFF_W'(smf_pkg::SMP_MAX);
    lo = -hi - smf_pkg::DIFF_W'(1);
    if (v > hi) begin
      return hi[smf_pkg::SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[smf_pkg::SAMPLE_BITS-1:0];
    end
    return v[smf_pkg::SAMPLE_BITS-1:0];
  endfunction

  // Config registers
  logic                            cfg_mode_q;
  logic [smf_pkg::WLEN_W-1:0]      cfg_wlen_q;
  logic [smf_pkg::ALPHA_W-1:0]     cfg_alpha_q;

  // Control and record state
  state_e                          state_q;
  logic [smf_pkg::CNT_W-1:0]       k_q;
  logic                            rd_vld_q;
  logic [smf_pkg::PTR_W-1:0]       wp_q;
  logic [smf_pkg::CNT_W-1:0]       seen_q;
  logic [smf_pkg::CRS_W-1:0]       crossings_q;
  logic [1:0]                      prev_q;      // {negative, positive}
  logic signed [smf_pkg::SMOOTH_W-1:0] smooth_q;
  logic                            out_valid_q;

  // Per-beat datapath registers
  logic signed [smf_pkg::SAMPLE_BITS-1:0] x_q;
  logic                            last_q;
  logic [smf_pkg::PTR_W-1:0]       base_q;
  logic [smf_pkg::CNT_W-1:0]       n_q;
  logic [smf_pkg::CNT_W-1:0]       w_q;
  logic                            first_q;
  logic signed [smf_pkg::DIFF_W-1:0] d_q;
  logic signed [smf_pkg::PROD_W-1:0] prod_q;
  logic signed [smf_pkg::SUM_W-1:0]  sum_q;
  logic [smf_pkg::CRS_W-1:0]       cross_res_q;
  logic signed [smf_pkg::SAMPLE_BITS-1:0] ys_q;
  logic signed [smf_pkg::SAMPLE_BITS-1:0] out_filt_q;
  logic [smf_pkg::CRS_W-1:0]       out_cross_q;
  logic                            out_last_q;

  // Combinational
  logic                            accept;
  logic signed [smf_pkg::SAMPLE_BITS-1:0] x;
  logic                            s_pos;
  logic                            s_neg;
  logic                            same_sign;
  logic                            cross_inc;
  logic [smf_pkg::CRS_W-1:0]       cross_new;
  logic [smf_pkg::CNT_W-1:0]       w_eff;
  logic [smf_pkg::CNT_W:0]         seen_inc;
  logic [smf_pkg::CNT_W-1:0]       n_new;
  logic [smf_pkg::CNT_W-1:0]       seen_new;
  logic signed [smf_pkg::SMOOTH_W-1:0] x_frac;
  logic signed [smf_pkg::SMOOTH_W-1:0] xq_frac;
  logic signed [smf_pkg::DIFF_W-1:0]   d_new;
  logic [smf_pkg::ALPHA_W-1:0]     a_sat;
  logic signed [smf_pkg::PROD_W-1:0]   prod_rnd;
  logic signed [smf_pkg::PROD_W-1:0]   step_w;
  logic signed [smf_pkg::DIFF_W-1:0]   smooth_sum;
  logic signed [smf_pkg::SMOOTH_W-1:0] smooth_new;
  logic signed [smf_pkg::DIFF_W-1:0]   ys_rnd;
  logic signed [smf_pkg::DIFF_W-1:0]   ys_w;
  logic                            rd_issue;
  logic                            sum_end;
  logic                            out_free;
  logic [smf_pkg::PTR_W-1:0]       rd_addr;
  logic [smf_pkg::SAMPLE_BITS-1:0] rd_data;
  smf_pkg::div_req_t               div_req;
  logic                            div_done;
  logic signed [smf_pkg::SUM_W-1:0] div_quot;

  // Config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q  <= smf_pkg::MODE_RST;
      cfg_wlen_q  <= smf_pkg::WLEN_RST;
      cfg_alpha_q <= smf_pkg::ALPHA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smf_pkg::CFG_MODE:  cfg_mode_q  <= cfg_wdata_i[0];
        smf_pkg::CFG_WLEN:  cfg_wlen_q  <= cfg_wdata_i[smf_pkg::WLEN_W-1:0];
        smf_pkg::CFG_ALPHA: cfg_alpha_q <= cfg_wdata_i[smf_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_ch_i.valid && (state_q == ST_IDLE);
  assign x      = in_ch_i.sample;

  // Crossing count, window length and record bookkeeping at accept
  always_comb begin
    s_pos     = !x[smf_pkg::SAMPLE_BITS-1] && (|x);
    s_neg     = x[smf_pkg::SAMPLE_BITS-1];
    same_sign = (prev_q[0] && s_pos) || (prev_q[1] && s_neg);
    cross_inc = (seen_q != '0) && !same_sign && (crossings_q != '1);
    cross_new = crossings_q + smf_pkg::CRS_W'(cross_inc);

    if (cfg_wlen_q == '0) begin
      w_eff = smf_pkg::CNT_W'(1);
    end else if (int'(cfg_wlen_q) > smf_pkg::MAX_WINDOW) begin
      w_eff = smf_pkg::CNT_W'(smf_pkg::MAX_WINDOW);
    end else begin
      w_eff = smf_pkg::CNT_W'(cfg_wlen_q);
    end

    seen_inc = {1'b0, seen_q} + (smf_pkg::CNT_W + 1)'(1);
    n_new    = (seen_inc > {1'b0, w_eff}) ? w_eff : seen_inc[smf_pkg::CNT_W-1:0];
    seen_new = (seen_q == smf_pkg::CNT_W'(smf_pkg::MAX_WINDOW)) ? seen_q
                                                             : seen_inc[smf_pkg::CNT_W-1:0];
  end

  // Exponential smoothing: difference at accept, product next, update at sum end
  always_comb begin
    x_frac  = {x[smf_pkg::SAMPLE_BITS-1], x, {smf_pkg::FRAC_BITS{1'b0}}};
    xq_frac = {x_q[smf_pkg::SAMPLE_BITS-1], x_q, {smf_pkg::FRAC_BITS{1'b0}}};
    d_new   = smf_pkg::DIFF_W'(x_frac) - smf_pkg::DIFF_W'(smooth_q);
    a_sat   = (cfg_alpha_q > smf_pkg::ALPHA_ONE) ? smf_pkg::ALPHA_ONE : cfg_alpha_q;

    prod_rnd   = prod_q + (smf_pkg::PROD_W'(1) << (smf_pkg::FRAC_BITS - 1));
    step_w     = prod_rnd >>> smf_pkg::FRAC_BITS;
    smooth_sum = smf_pkg::DIFF_W'(smooth_q) + step_w[smf_pkg::DIFF_W-1:0];
    smooth_new = first_q ? xq_frac : smooth_sum[smf_pkg::SMOOTH_W-1:0];
    ys_rnd     = smf_pkg::DIFF_W'(smooth_new)
               + (smf_pkg::DIFF_W'(1) << (smf_pkg::FRAC_BITS - 1));
    ys_w       = ys_rnd >>> smf_pkg::FRAC_BITS;
  end

  // Window read loop: one history read per cycle, data in the next cycle
  assign rd_issue = (state_q == ST_SUM) && (k_q < n_q);
  assign sum_end  = (state_q == ST_SUM) && !rd_issue && !rd_vld_q;
  assign rd_addr  = base_q - k_q[smf_pkg::PTR_W-1:0];
  assign out_free = !out_valid_q || out_ch_o.ready;

  assign div_req.start    = sum_end;
  assign div_req.dividend = sum_q;
  assign div_req.divisor  = w_q;

  smf_hist_ram #(
    .DEPTH (smf_pkg::MAX_WINDOW),
    .WIDTH (smf_pkg::SAMPLE_BITS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (x),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  smf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Sequencer and record state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      wp_q        <= '0;
      seen_q      <= '0;
      crossings_q <= '0;
      prev_q      <= '0;
      smooth_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q     <= ST_SUM;
            k_q         <= '0;
            rd_vld_q    <= 1'b0;
            wp_q        <= in_ch_i.last_in_record ? '0 : wp_q + smf_pkg::PTR_W'(1);
            seen_q      <= in_ch_i.last_in_record ? '0 : seen_new;
            crossings_q <= in_ch_i.last_in_record ? '0 : cross_new;
            prev_q      <= in_ch_i.last_in_record ? 2'b00 : {s_neg, s_pos};
          end
        end
        ST_SUM: begin
          k_q      <= k_q + smf_pkg::CNT_W'(rd_issue);
          rd_vld_q <= rd_issue;
          if (sum_end) begin
            state_q  <= ST_DIV;
            smooth_q <= last_q ? '0 : smooth_new;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= $signed({1'b0, a_sat}) * d_q;
    if (accept) begin
      x_q         <= x;
      last_q      <= in_ch_i.last_in_record;
      base_q      <= wp_q;
      n_q         <= n_new;
      w_q         <= w_eff;
      first_q     <= (seen_q == '0);
      d_q         <= d_new;
      cross_res_q <= cross_new;
      sum_q       <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + smf_pkg::SUM_W'($signed(rd_data));
    end
    if (sum_end) begin
      ys_q <= sat_smp(ys_w);
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_filt_q  <= cfg_mode_q ? ys_q : sat_smp(smf_pkg::DIFF_W'(div_quot));
      out_cross_q <= cross_res_q;
      out_last_q  <= last_q;
    end
  end

  assign in_ch_i.ready           = (state_q == ST_IDLE);
  assign out_ch_o.valid          = out_valid_q;
  assign out_ch_o.filtered       = out_filt_q;
  assign out_ch_o.crossing_count = out_cross_q;
  assign out_ch_o.is_last        = out_last_q;

`ifndef SYNTHESIS
  localparam logic signed [smf_pkg::SUM_W-1:0] QMAX = smf_pkg::SUM_W'(smf_pkg::SMP_MAX);

  // Read loop never runs past the window
  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (k_q <= n_q))
    else $error("history read count passed window");

  // End of record clears the record state
  a_record_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_ch_i.last_in_record) |=>
      (crossings_q == '0 && seen_q == '0 && wp_q == '0 && prev_q == 2'b00))
    else $error("record state not cleared after last beat");

  // Crossing count never falls within a record
  a_cross_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_ch_i.last_in_record) |=> (crossings_q >= $past(crossings_q)))
    else $error("crossing count decreased");

  // An average of samples stays within the sample range
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((div_quot <= QMAX) && (div_quot >= -QMAX - smf_pkg::SUM_W'(1))))
    else $error("divider quotient out of sample range");
`endif

endmodule

/* dv/tb.sv */
// Self-checking testbench for the smoothing filter core with zero-crossing count.
`timescale 1ns / 100ps

module tb;
  import smf_pkg::*;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic [CRS_W-1:0]              crossing_count;
    logic                          is_last;
  } filter_result_t;

  // Scoreboard: tracks record state, predicts each result and compares in order
  class smooth_scoreboard;
    logic                 mode;
    logic [WLEN_W-1:0]    wlen;
    logic [ALPHA_W-1:0]   alpha_q15;
    int                   hist [MAX_WINDOW];
    int                   wr_ptr;
    int                   seen;
    longint               smooth_acc;
    int                   prev_sign;
    logic [CRS_W-1:0]     crossings;
    filter_result_t       expected_results [$];
    int                   mismatches;
    int                   results_seen;

    function new();
      mode         = MODE_RST;
      wlen         = WLEN_RST;
      alpha_q15    = ALPHA_RST;
      mismatches   = 0;
      results_seen = 0;
      clear_record();
    endfunction

    function void clear_record();
      foreach (hist[i]) hist[i] = 0;
      wr_ptr     = 0;
      seen       = 0;
      smooth_acc = 0;
      prev_sign  = 0;
      crossings  = '0;
    endfunction

    // Registers keep only their own width of the write data
    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE:  mode = data[0];
        CFG_WLEN:  wlen = data[WLEN_W-1:0];
        CFG_ALPHA: alpha_q15 = data[ALPHA_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] smp, logic lst);
      int             x, s, w, n;
      longint         win_sum, avg, a, d, ys, filt;
      filter_result_t r;
      x = smp;
      if (x > 0) s = 1;
      else if (x < 0) s = -1;
      else s = 0;

      // zero crossings: a pair with sign product <= 0, never on the first sample
      if (seen > 0 && prev_sign * s <= 0 && crossings != {CRS_W{1'b1}})
        crossings = crossings + 1;
      prev_sign = s;

      // moving average over the newest samples of this record
      w = wlen;
      if (w == 0) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      hist[wr_ptr] = x;
      n = seen + 1;
      if (n > w) n = w;
      win_sum = 0;
      for (int k = 0; k < n; k++)
        win_sum += hist[(wr_ptr + MAX_WINDOW - k) % MAX_WINDOW];
      avg = win_sum / w;

      // first-order smoothing, 15 fraction bits, round half up
      a = alpha_q15;
      if (a > (longint'(1) << FRAC_BITS)) a = longint'(1) << FRAC_BITS;
      if (seen == 0) begin
        smooth_acc = longint'(x) <<< FRAC_BITS;
      end else begin
        d = (longint'(x) <<< FRAC_BITS) - smooth_acc;
        smooth_acc += (a * d + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      end
      ys = (smooth_acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;

      filt = mode ? ys : avg;
      if (filt > SMP_MAX) filt = SMP_MAX;
      if (filt < -SMP_MAX - 1) filt = -SMP_MAX - 1;

      r.filtered       = SAMPLE_BITS'(filt);
      r.crossing_count = crossings;
      r.is_last        = lst;
      expected_results.push_back(r);

      wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
      if (seen < MAX_WINDOW) seen++;
      if (lst) clear_record();
    endfunction

    function void check_result(filter_result_t got);
      filter_result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with none expected: filtered %0d count %0d last %0b",
                   got.filtered, got.crossing_count, got.is_last);
        return;
      end
      want = expected_results.pop_front();
      if (got.filtered !== want.filtered || got.crossing_count !== want.crossing_count ||
          got.is_last !== want.is_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected filtered %0d count %0d last %0b, got %0d %0d %0b",
                   results_seen, want.filtered, want.crossing_count, want.is_last,
                   got.filtered, got.crossing_count, got.is_last);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    send_idle_pct;
  int                    stall_pct;
  int                    items_sent;
  int                    records_sent;
  int                    mid_record_writes;
  smooth_scoreboard      sb;

  smf_in_if  in_if ();
  smf_out_if out_if ();

  smoothing_filter_mavg_or_first_order_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch_i     (in_if),
    .out_ch_o    (out_if)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin
    filter_result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.filtered       = out_if.filtered;
      got.crossing_count = out_if.crossing_count;
      got.is_last        = out_if.is_last;
      sb.check_result(got);
    end
  end

  // Random upper bits above a register's width must be ignored
  function automatic logic [CFG_DATA_W-1:0] with_junk(int v, int width);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data = (data << width) | CFG_DATA_W'(v);
    return data;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(int m, int w, int a);
    write_reg(CFG_MODE, with_junk(m, 1));
    write_reg(CFG_WLEN, with_junk(w, WLEN_W));
    write_reg(CFG_ALPHA, CFG_DATA_W'(a));
  endtask

  // Drive one sample beat; valid stays high on return
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.sample         <= smp;
    in_if.last_in_record <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(smp, lst);
    items_sent++;
    if (lst) records_sent++;
  endtask

  // Stop sending and wait until every expected result is back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // One record with random content; rarely switches mode or window mid-record
  task automatic send_random_record(int len);
    int                            kind;
    int                            walk;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          lst;
    kind = $urandom_range(0, 3);
    walk = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: smp = SAMPLE_BITS'($urandom);
        1: smp = SAMPLE_BITS'(int'($urandom_range(0, 6)) - 3);
        2: smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        default: begin
          walk += int'($urandom_range(0, 4000)) - 2000;
          if (walk > SMP_MAX) walk = SMP_MAX;
          if (walk < -SMP_MAX - 1) walk = -SMP_MAX - 1;
          smp = SAMPLE_BITS'(walk);
        end
      endcase
      lst = (i == len - 1);
      send_sample(smp, lst);
      if (!lst && $urandom_range(99) < 2) begin
        drain();
        write_reg(CFG_MODE, with_junk(!sb.mode, 1));
        if ($urandom_range(0, 1)) write_reg(CFG_WLEN, with_junk($urandom_range(1, 64), WLEN_W));
        mid_record_writes++;
      end
    end
  endtask

  // Stimulus
  initial begin
    int target;
    int len;
    sb                   = new();
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    in_if.valid          = 1'b0;
    in_if.sample         = '0;
    in_if.last_in_record = 1'b0;
    out_if.ready         = 1'b0;
    send_idle_pct        = 0;
    stall_pct            = 0;
    items_sent           = 0;
    records_sent         = 0;
    mid_record_writes    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config, full-scale values, zeros, one-sample record
    send_sample(16'sh7FFF, 0); send_sample(16'sh7FFF, 0); send_sample(16'sh8000, 0);
    send_sample(0, 0);         send_sample(0, 0);         send_sample(-1, 0);
    send_sample(1, 0);         send_sample(16'sh7FFF, 1);
    send_sample(16'sh8000, 1);

    // Window zero acts as one, alpha above one saturates; mode switch mid-record
    drain();
    set_config(1, 0, 16'hFFFF);
    send_sample(1000, 0); send_sample(-2000, 0);
    drain();
    write_reg(CFG_MODE, with_junk(0, 1));
    mid_record_writes++;
    send_sample(3000, 0); send_sample(16'sh8000, 1);

    // Window above the maximum saturates, alpha zero holds the first sample
    drain();
    set_config(1, 127, 0);
    send_sample(16'sh7FFF, 0); send_sample(16'sh8000, 0); send_sample(12345, 0);
    send_sample(0, 1);
    drain();
    write_reg(CFG_MODE, with_junk(0, 1));
    send_sample(16'sh8000, 0); send_sample(16'sh8000, 0); send_sample(16'sh8000, 0);
    send_sample(16'sh7FFF, 1);

    // Zero samples count as crossings on both sides
    drain();
    set_config(1, 3, 32768);
    send_sample(0, 0); send_sample(0, 0); send_sample(5, 0); send_sample(-5, 1);

    // Random phases: each a config setting and an idling pattern
    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: set_config(0, 1, $urandom_range(0, 65535));
        1: set_config(1, 64, 32768);
        2: set_config(0, 64, 0);
        3: set_config(1, $urandom_range(2, 16), 1);
        4: set_config(0, $urandom_range(2, 16), $urandom_range(0, 65535));
        5: set_config(1, 0, 65535);
        6: set_config(0, 100, $urandom_range(0, 32768));
        default: set_config(1, $urandom_range(1, 64), $urandom_range(0, 32768));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      target = items_sent + 60;
      while (items_sent < target) begin
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 24) : $urandom_range(60, 90);
        send_random_record(len);
      end
    end

    drain();
    repeat (150) @(posedge clk_i);

    $display("Run covered %0d samples in %0d records, both filter modes, windows 0..127,",
             items_sent, records_sent);
    $display("alpha 0..65535 and %0d mid-record config changes; %0d results checked.",
             mid_record_writes, sb.results_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("FAILURE");
    $finish;
  end

endmodule
